FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define BTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define BTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: design/btt_pkg.sv
// Shared types, constants and helpers of the brace template tokenizer.
package btt_pkg;

  localparam int MAX_LEN = 1024;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    KIND_EXPR      = 3'd0,
    KIND_ESC_OPEN  = 3'd1,
    KIND_ESC_CLOSE = 3'd2,
    KIND_LONE      = 3'd3,
    KIND_SYNTAX    = 3'd4,
    KIND_SPEC      = 3'd5,
    KIND_END       = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    FMT_NONE  = 2'd0,
    FMT_INT   = 2'd1,
    FMT_FLOAT = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_OPEN  = 2'd1,
    PEND_CLOSE = 2'd2
  } pend_t;

  typedef struct packed {
    kind_t            token_kind;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;
    logic [POS_W-1:0] name_end;
    fmt_t             format_kind;
    logic [7:0]       whole_digits;
    logic             whole_given;
    logic [7:0]       fraction_digits;
  } res_t;

  // Up to three results caused by one byte, in emit order.
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MAX_RES-1:0]    slot;
  } group_t;

  // Open expression bookkeeping.
  typedef struct packed {
    logic             active;
    logic [POS_W-1:0] start;
    logic             colon;
    logic [POS_W-1:0] colon_pos;
    logic [7:0]       hash_pre;
    logic [7:0]       hash_post;
    logic [1:0]       dots;
    logic             foreign;
  } expr_t;

  function automatic res_t mk_range(kind_t k, logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    res_t r;
    r                 = '0;
    r.token_kind      = k;
    r.range_start     = s;
    r.range_end       = e;
    r.format_kind     = FMT_NONE;
    return r;
  endfunction

endpackage

FILE: design/btt_core.sv
// Scan state and per-byte token decode; builds the result group for one byte.
module btt_core import btt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output group_t     grp
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  pend_t            pend_r, pend_nxt;
  expr_t            exp_r, exp_nxt;

  logic             act;
  logic             m_v, t_v;
  res_t             m_res, t_res, e_res;
  logic             do_in, do_out;
  expr_t            e;
  logic [POS_W-1:0] size;
  logic [1:0]       n;

  always_comb begin
    act      = (pos_r < POS_MAX);
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    e        = exp_r;
    m_v      = 1'b0;
    m_res    = mk_range(KIND_END, '0, '0);
    do_in    = 1'b0;
    do_out   = 1'b0;

    if (act) begin
      pos_nxt = pos_r + POS_ONE;
      case (pend_r)
        PEND_OPEN: begin
          pend_nxt = PEND_NONE;
          if (text_byte == CH_OPEN) begin
            m_v   = 1'b1;
            m_res = mk_range(KIND_ESC_OPEN, pos_r - POS_ONE, pos_r + POS_ONE);
          end else begin
            e           = '0;
            e.active    = 1'b1;
            e.start     = pos_r - POS_ONE;
            do_in       = 1'b1;
          end
        end
        PEND_CLOSE: begin
          pend_nxt = PEND_NONE;
          if (text_byte == CH_CLOSE) begin
            m_v   = 1'b1;
            m_res = mk_range(KIND_ESC_CLOSE, pos_r - POS_ONE, pos_r + POS_ONE);
          end else begin
            m_v    = 1'b1;
            m_res  = mk_range(KIND_LONE, pos_r - POS_ONE, pos_r);
            do_out = 1'b1;
          end
        end
        default: begin
          if (exp_r.active) do_in = 1'b1;
          else              do_out = 1'b1;
        end
      endcase

      if (do_out) begin
        if (text_byte == CH_OPEN)       pend_nxt = PEND_OPEN;
        else if (text_byte == CH_CLOSE) pend_nxt = PEND_CLOSE;
      end

      if (do_in) begin
        if (text_byte == CH_OPEN) begin
          // Nested open: report, then rescan the brace from outside.
          m_v      = 1'b1;
          m_res    = mk_range(KIND_SYNTAX, e.start, pos_r);
          e.active = 1'b0;
          pend_nxt = PEND_OPEN;
        end else if (text_byte == CH_CLOSE) begin
          e.active = 1'b0;
          m_v      = 1'b1;
          m_res    = mk_range(KIND_EXPR, e.start, pos_r + POS_ONE);
          if (!e.colon) begin
            m_res.name_end = pos_r;
          end else if (e.foreign || e.dots > 2'd1 || (e.dots == 2'd0 && e.hash_pre == 8'd0)
                       || (e.dots != 2'd0 && e.hash_post == 8'd0)) begin
            m_res.token_kind = KIND_SPEC;
            m_res.name_end   = e.colon_pos;
          end else if (e.dots == 2'd0) begin
            m_res.name_end     = e.colon_pos;
            m_res.format_kind  = FMT_INT;
            m_res.whole_digits = e.hash_pre;
            m_res.whole_given  = 1'b1;
          end else begin
            m_res.name_end        = e.colon_pos;
            m_res.format_kind     = FMT_FLOAT;
            m_res.whole_digits    = e.hash_pre;
            m_res.whole_given     = (e.hash_pre != 8'd0);
            m_res.fraction_digits = e.hash_post;
          end
        end else if (e.colon) begin
          if (text_byte == CH_HASH) begin
            if (e.dots == 2'd0) begin
              if (e.hash_pre != 8'hFF) e.hash_pre = e.hash_pre + 8'd1;
            end else if (e.hash_post != 8'hFF) begin
              e.hash_post = e.hash_post + 8'd1;
            end
          end else if (text_byte == CH_DOT) begin
            if (e.dots != 2'd2) e.dots = e.dots + 2'd1;
          end else begin
            e.foreign = 1'b1;
          end
        end else if (text_byte == CH_COLON) begin
          e.colon     = 1'b1;
          e.colon_pos = pos_r;
        end
      end
    end

    // End of template: flush what is still open, then the end marker.
    size  = pos_nxt;
    t_v   = 1'b0;
    t_res = mk_range(KIND_SYNTAX, e.start, size);
    e_res = mk_range(KIND_END, size, size);
    if (final_byte) begin
      case (pend_nxt)
        PEND_OPEN: begin
          t_v   = 1'b1;
          t_res = mk_range(KIND_SYNTAX, size - POS_ONE, size);
        end
        PEND_CLOSE: begin
          t_v   = 1'b1;
          t_res = mk_range(KIND_LONE, size - POS_ONE, size);
        end
        default: t_v = e.active;
      endcase
    end

    exp_nxt = e;
    if (final_byte) begin
      pos_nxt  = '0;
      pend_nxt = PEND_NONE;
      exp_nxt  = '0;
    end
  end

  // Pack results densely in emit order.
  always_comb begin
    grp      = '0;
    n        = 2'd0;
    if (m_v) begin
      grp.slot[n] = m_res;
      n           = n + 2'd1;
    end
    if (t_v) begin
      grp.slot[n] = t_res;
      n           = n + 2'd1;
    end
    if (final_byte) begin
      grp.slot[n] = e_res;
      n           = n + 2'd1;
    end
    grp.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pend_r <= PEND_NONE;
      exp_r  <= '0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      exp_r  <= exp_nxt;
    end
  end

endmodule

FILE: design/btt_outq.sv
// Result group register; hands out its results one beat at a time.
module btt_outq import btt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  group_t grp_in,
  output logic   free,
  output logic   out_valid,
  output logic   out_last,
  input  logic   out_ready,
  output res_t   out_res
);

  logic [1:0]         cnt_r;
  logic [1:0]         idx_r;
  res_t [MAX_RES-1:0] slot_r;
  logic               beat_done;

  assign out_valid = (cnt_r != 2'd0);
  assign out_last  = (idx_r == cnt_r - 2'd1);
  assign out_res   = slot_r[idx_r];
  assign beat_done = out_valid && out_ready;
  assign free      = !out_valid || (beat_done && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= grp_in.cnt;
      idx_r <= 2'd0;
    end else if (beat_done) begin
      if (out_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot_r <= grp_in.slot;
  end

endmodule

FILE: design/brace_template_tokenizer.sv
// Top level of the brace template tokenizer: input register, scanner, result queue.
// Path: input register, then the combinational scanner, then the result group register.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_tready is high; more results (up to three) hold the register until all are taken.
// The result group register sets the rate: it takes a new group only as the old drains.
// Reset: synchronous, active-low rst_n; clears position, brace and expression state.
module brace_template_tokenizer import btt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Template bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // final_byte
  // Tokens
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [10:0] range_start, [21:11] range_end,
                                  // [32:22] name_end, [34:33] format_kind,
                                  // [42:35] whole_digits, [43] whole_given,
                                  // [51:44] fraction_digits, [55:52] zero
  output logic [2:0]  out_tuser,  // token_kind
  output logic        out_tlast   // run_last
);

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       final_r;
  logic       advance;
  logic       grp_free;
  group_t     grp;
  res_t       res;

  // Advance the held byte through the scanner once the result group is free.
  assign advance   = in_v_r && grp_free;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // Hold the payload until the scanner takes it.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      byte_r  <= in_tdata;
      final_r <= in_tlast;
    end
  end

  btt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .text_byte  (byte_r),
    .final_byte (final_r),
    .grp        (grp)
  );

  // A byte with no results still loads, which just leaves the queue empty.
  btt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .grp_in    (grp),
    .free      (grp_free),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.token_kind;
  assign out_tdata = {4'd0, res.fraction_digits, res.whole_given, res.whole_digits,
                      res.format_kind, res.name_end, res.range_end, res.range_start};

endmodule

FILE: design/btt_checker.sv
// Port-level checks on the tokenizer result stream, bound to the top level.
`include "assert_macros.svh"

module btt_checker import btt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  logic is_end;
  logic is_expr;

  assign is_end  = out_tvalid && (out_tuser == KIND_END);
  assign is_expr = out_tvalid && (out_tuser == KIND_EXPR);

  // A stalled beat holds.
  `BTT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // The end token always closes the run of its byte.
  `BTT_ASSERT_NOW(a_end_last, is_end, out_tlast)

  // The end token is an empty range at the template length.
  `BTT_ASSERT_NOW(a_end_empty, is_end, out_tdata[10:0] == out_tdata[21:11])

  // An expression covers at least its two braces and its name ends inside it.
  `BTT_ASSERT_NOW(a_expr_range, is_expr,
    (out_tdata[21:11] > out_tdata[10:0] + 11'd1) && (out_tdata[32:22] < out_tdata[21:11]))

endmodule

bind brace_template_tokenizer btt_checker u_btt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: test/tb_brace_template_tokenizer.sv
// Self-checking testbench for the brace template tokenizer: byte stream in, tokens out.
module tb_brace_template_tokenizer;
  import btt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 280;

  // One template byte waiting to be sent, or a marker that makes the sender
  // wait until every expected token has come back.
  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic       pause;
  } text_beat_t;

  // One expected token.
  typedef struct {
    kind_t            kind;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] stop;
    logic [POS_W-1:0] name_end;
    fmt_t             fmt;
    logic [7:0]       whole;
    logic             given;
    logic [7:0]       frac;
    logic             last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  brace_template_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  text_beat_t pending_bytes[$];
  token_t     expected_tokens[$];
  token_t     step_tokens[$];

  bit in_taken;
  int bytes_taken;
  int tokens_seen;
  int mismatches;
  int cycle_count;
  int hold_cycles;
  bit hold_done;

  // Scanner state mirrored from the block.
  int    scan_pos;
  pend_t scan_pend = PEND_NONE;
  bit    scan_in_expr;
  int    scan_expr_start;
  bit    scan_colon;
  int    scan_colon_at;
  int    scan_hash_pre;
  int    scan_hash_post;
  int    scan_dots;
  bit    scan_foreign;

  // Random idling is switched off over one stretch of the run.
  wire calm = (bytes_taken >= 100) && (bytes_taken < 180);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------

  // Queue one token for the current byte; a byte never yields more than MAX_RES.
  task automatic emit_token(kind_t k, int s, int e, int ne = 0, fmt_t f = FMT_NONE,
                            int w = 0, bit g = 1'b0, int fr = 0);
    token_t t;
    if (step_tokens.size() < MAX_RES) begin
      t.kind     = k;
      t.start    = POS_W'(s);
      t.stop     = POS_W'(e);
      t.name_end = POS_W'(ne);
      t.fmt      = f;
      t.whole    = 8'(w);
      t.given    = g;
      t.frac     = 8'(fr);
      t.last     = 1'b0;
      step_tokens.push_back(t);
    end
  endtask

  // Hold a brace seen outside an expression until the next byte decides it.
  task automatic outside_char(logic [7:0] c);
    if (c == CH_OPEN) begin
      scan_pend = PEND_OPEN;
    end else if (c == CH_CLOSE) begin
      scan_pend = PEND_CLOSE;
    end
  endtask

  // Closing brace: classify the specifier after the first colon.
  task automatic close_expr(int p);
    scan_in_expr = 1'b0;
    if (!scan_colon) begin
      emit_token(KIND_EXPR, scan_expr_start, p + 1, p);
    end else if (scan_foreign || scan_dots > 1 || (scan_dots == 0 && scan_hash_pre == 0)) begin
      emit_token(KIND_SPEC, scan_expr_start, p + 1, scan_colon_at);
    end else if (scan_dots == 0) begin
      emit_token(KIND_EXPR, scan_expr_start, p + 1, scan_colon_at, FMT_INT,
                 scan_hash_pre, 1'b1);
    end else if (scan_hash_post == 0) begin
      emit_token(KIND_SPEC, scan_expr_start, p + 1, scan_colon_at);
    end else begin
      emit_token(KIND_EXPR, scan_expr_start, p + 1, scan_colon_at, FMT_FLOAT,
                 scan_hash_pre, scan_hash_pre != 0, scan_hash_post);
    end
  endtask

  task automatic inside_char(logic [7:0] c, int p);
    if (c == CH_OPEN) begin
      // Nested open brace: error up to it, then rescan it outside.
      emit_token(KIND_SYNTAX, scan_expr_start, p);
      scan_in_expr = 1'b0;
      outside_char(c);
    end else if (c == CH_CLOSE) begin
      close_expr(p);
    end else if (scan_colon) begin
      if (c == CH_HASH) begin
        if (scan_dots == 0) begin
          if (scan_hash_pre < 255) scan_hash_pre++;
        end else if (scan_hash_post < 255) begin
          scan_hash_post++;
        end
      end else if (c == CH_DOT) begin
        if (scan_dots < 2) scan_dots++;
      end else begin
        scan_foreign = 1'b1;
      end
    end else if (c == CH_COLON) begin
      scan_colon    = 1'b1;
      scan_colon_at = p;
    end
  endtask

  // Advance the tokenizer state by one accepted byte and queue its tokens.
  task automatic scan_byte(logic [7:0] c, logic fin);
    int p;
    int size;
    p = scan_pos;
    step_tokens.delete();
    if (p < MAX_LEN) begin
      if (scan_pend == PEND_OPEN) begin
        scan_pend = PEND_NONE;
        if (c == CH_OPEN) begin
          emit_token(KIND_ESC_OPEN, p - 1, p + 1);
        end else begin
          scan_in_expr    = 1'b1;
          scan_expr_start = p - 1;
          scan_colon      = 1'b0;
          scan_colon_at   = 0;
          scan_hash_pre   = 0;
          scan_hash_post  = 0;
          scan_dots       = 0;
          scan_foreign    = 1'b0;
          inside_char(c, p);
        end
      end else if (scan_pend == PEND_CLOSE) begin
        scan_pend = PEND_NONE;
        if (c == CH_CLOSE) begin
          emit_token(KIND_ESC_CLOSE, p - 1, p + 1);
        end else begin
          emit_token(KIND_LONE, p - 1, p);
          outside_char(c);
        end
      end else if (scan_in_expr) begin
        inside_char(c, p);
      end else begin
        outside_char(c);
      end
      scan_pos = p + 1;
    end
    if (fin) begin
      // End of template: flush whatever is still open, then the end token.
      size = scan_pos;
      if (scan_pend == PEND_OPEN) begin
        emit_token(KIND_SYNTAX, size - 1, size);
      end else if (scan_pend == PEND_CLOSE) begin
        emit_token(KIND_LONE, size - 1, size);
      end else if (scan_in_expr) begin
        emit_token(KIND_SYNTAX, scan_expr_start, size);
      end
      emit_token(KIND_END, size, size);
      scan_pos        = 0;
      scan_pend       = PEND_NONE;
      scan_in_expr    = 1'b0;
      scan_expr_start = 0;
      scan_colon      = 1'b0;
      scan_colon_at   = 0;
      scan_hash_pre   = 0;
      scan_hash_post  = 0;
      scan_dots       = 0;
      scan_foreign    = 1'b0;
    end
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // Print one line per mismatch, at most a few dozen, and count them all.
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at token %0d, %s: got %0d, want %0d", tokens_seen, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] c);
    text_beat_t b;
    b.data  = c;
    b.fin   = 1'b0;
    b.pause = 1'b0;
    pending_bytes.push_back(b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Mark the last queued byte as the end of its template.
  task automatic end_template();
    pending_bytes[$].fin = 1'b1;
  endtask

  task automatic add_repeat(logic [7:0] c, int n);
    for (int i = 0; i < n; i++) add_byte(c);
  endtask

  task automatic add_name(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(8'($urandom_range(8'h61, 8'h7A)));
      end
    end
  endtask

  // Build one template out of random pieces, with a brace expression the most frequent piece.
  task automatic add_random_template();
    int pieces;
    int sel;
    logic [7:0] junk[5];
    junk = '{CH_OPEN, CH_CLOSE, CH_COLON, CH_HASH, CH_DOT};
    pieces = $urandom_range(1, 6);
    for (int k = 0; k < pieces; k++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1: begin
          for (int i = $urandom_range(1, 4); i > 0; i--) add_byte(8'($urandom_range(0, 255)));
        end
        2: begin
          add_repeat($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE, 2);
        end
        3, 4, 5, 6: begin
          add_byte(CH_OPEN);
          add_name($urandom_range(0, 3));
          if ($urandom_range(0, 3) != 0) begin
            add_byte(CH_COLON);
            case ($urandom_range(0, 2))
              0: add_repeat(CH_HASH, $urandom_range(1, 4));
              1: begin
                add_repeat(CH_HASH, $urandom_range(0, 3));
                add_byte(CH_DOT);
                add_repeat(CH_HASH, $urandom_range(1, 3));
              end
              default: begin
                for (int i = $urandom_range(0, 4); i > 0; i--) begin
                  case ($urandom_range(0, 3))
                    0: add_byte(CH_HASH);
                    1: add_byte(CH_DOT);
                    2: add_byte(CH_COLON);
                    default: add_byte(8'($urandom_range(8'h61, 8'h7A)));
                  endcase
                end
              end
            endcase
          end
          add_byte(CH_CLOSE);
        end
        7: begin
          add_byte(CH_CLOSE);
        end
        8: begin
          // Open an expression and leave it unclosed.
          add_byte(CH_OPEN);
          add_name($urandom_range(0, 2));
        end
        default: begin
          for (int i = $urandom_range(1, 3); i > 0; i--) begin
            add_byte(junk[$urandom_range(0, 4)]);
          end
        end
      endcase
    end
    end_template();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, stimulus, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin
    text_beat_t wait_mark;
    int before_count;

    // Doubled braces, a lone close, then an open brace as the final byte.
    add_text("{{}}}{");
    end_template();
    // Float specifier.
    add_text("{n:#.#}");
    end_template();
    // Empty specifier, then a close brace left pending at the end.
    add_text("{:}}");
    end_template();
    // Nested open brace; the rescanned brace opens an expression left unclosed.
    add_text("{a{");
    add_byte(8'hFF);
    end_template();
    // Single byte template.
    add_byte(8'h00);
    end_template();

    // Random templates, with one pause in the middle for a full drain.
    before_count = pending_bytes.size();
    while (pending_bytes.size() - before_count < RANDOM_BYTES / 2) add_random_template();
    wait_mark.data  = 8'h00;
    wait_mark.fin   = 1'b0;
    wait_mark.pause = 1'b1;
    pending_bytes.push_back(wait_mark);
    before_count = pending_bytes.size();
    while (pending_bytes.size() - before_count < RANDOM_BYTES / 2) add_random_template();

    // Hold reset low, then release it at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be taken, then for every token to arrive.
    while (pending_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on each byte beat, check each token beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    token_t want;
    if (rst_n && in_tvalid && in_tready) begin
      scan_byte(in_tdata, in_tlast);
      in_taken = 1'b1;
      bytes_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token with none expected, kind", out_tuser, -1);
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser != want.kind) report_mismatch("token_kind", out_tuser, want.kind);
        if (out_tdata[10:0] != want.start)
          report_mismatch("range_start", out_tdata[10:0], want.start);
        if (out_tdata[21:11] != want.stop)
          report_mismatch("range_end", out_tdata[21:11], want.stop);
        if (out_tdata[32:22] != want.name_end)
          report_mismatch("name_end", out_tdata[32:22], want.name_end);
        if (out_tdata[34:33] != want.fmt)
          report_mismatch("format_kind", out_tdata[34:33], want.fmt);
        if (out_tdata[42:35] != want.whole)
          report_mismatch("whole_digits", out_tdata[42:35], want.whole);
        if (out_tdata[43] != want.given)
          report_mismatch("whole_given", out_tdata[43], want.given);
        if (out_tdata[51:44] != want.frac)
          report_mismatch("fraction_digits", out_tdata[51:44], want.frac);
        if (out_tdata[55:52] != 4'h0) report_mismatch("padding", out_tdata[55:52], 0);
        if (out_tlast != want.last) report_mismatch("run_last", out_tlast, want.last);
      end
      tokens_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver, falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    logic still_offered;
    logic offer;
    if (rst_n) begin
      // Drop the byte just taken; keep offering one that was not taken.
      still_offered = in_tvalid && !in_taken;
      if (in_taken) begin
        void'(pending_bytes.pop_front());
        in_taken = 1'b0;
      end
      if (!still_offered) begin
        // Release the pause marker only once every expected token is back.
        if (pending_bytes.size() > 0 && pending_bytes[0].pause &&
            expected_tokens.size() == 0) begin
          void'(pending_bytes.pop_front());
        end
        offer = pending_bytes.size() > 0 && !pending_bytes[0].pause &&
                (calm || $urandom_range(0, 99) >= 10);
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= pending_bytes[0].data;
          in_tlast <= pending_bytes[0].fin;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token receiver, falling edge: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (!hold_done && bytes_taken >= 40) begin
      // Stall long enough for the block to fill and push back on its input.
      hold_done   = 1'b1;
      hold_cycles = 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
